>>> rtl/pfx_pkg.sv
// ----------------------------------------------------------------------------
// pfx_pkg: shared definitions for the postfix expression evaluator
// Symbol codes, operation and status codes, and the control structs that
// pass between the sequencer and the serial arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pfx_pkg;

  // Default depth of the operand stack.
  localparam int STACK_DEPTH_DEF = 16;

  // Operand and symbol widths.
  localparam int DATA_W = 32;
  localparam int SYM_W  = 8;
  localparam int CNT_W  = $clog2(DATA_W);

  // Expression characters.
  localparam logic [SYM_W-1:0] SYM_ADD  = 8'd43;
  localparam logic [SYM_W-1:0] SYM_SUB  = 8'd45;
  localparam logic [SYM_W-1:0] SYM_MUL  = 8'd42;
  localparam logic [SYM_W-1:0] SYM_DIV  = 8'd47;
  localparam logic [SYM_W-1:0] SYM_ZERO = 8'd48;

  // Operation codes of the serial unit.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  // Request to the serial unit.
  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_ctl_t;

  // Completion report from the serial unit.
  typedef struct packed {
    logic done;
    logic divz;
  } alu_sts_t;

  // Keep the first recorded error of an expression.
  function automatic logic [1:0] merge_err(input logic [1:0] cur, input logic [1:0] code);
    merge_err = (cur == ST_OK) ? code : cur;
  endfunction

endpackage

`default_nettype wire

>>> rtl/pfx_serial_alu.sv
// ----------------------------------------------------------------------------
// pfx_serial_alu: bit-serial arithmetic unit
// Add and subtract one bit per cycle, multiply by shift and add one
// multiplier bit per cycle, divide by restoring one quotient bit per cycle.
// Every operation passes through a load step, the bit-serial work and a finish
// step; done is raised in the cycle after the finish step.
// ----------------------------------------------------------------------------
`default_nettype none

module pfx_serial_alu (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire pfx_pkg::alu_ctl_t          ctl,
  input  wire logic [pfx_pkg::DATA_W-1:0] x,
  input  wire logic [pfx_pkg::DATA_W-1:0] y,
  output pfx_pkg::alu_sts_t               sts,
  output logic [pfx_pkg::DATA_W-1:0]      result
);

  localparam int W = pfx_pkg::DATA_W;

  logic [W-1:0]               a_r, b_r, acc_r, rem_r, res_r;
  logic                       carry_r, neg_r, dz_r, run_r, fin_r, done_r;
  logic [1:0]                 op_r;
  logic [pfx_pkg::CNT_W-1:0]  cnt_r;
  logic [W:0]                 trial;
  logic                       sum_bit, carry_nxt;

  // Serial adder cell and the divider's trial subtraction.
  assign sum_bit   = a_r[0] ^ b_r[0] ^ carry_r;
  assign carry_nxt = (a_r[0] & b_r[0]) | (carry_r & (a_r[0] ^ b_r[0]));
  assign trial     = {rem_r, a_r[W-1]} - {1'b0, b_r};

  // Control: load, run through the bits, then finish.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= fin_r;
      fin_r  <= run_r && (cnt_r == pfx_pkg::CNT_W'(W - 1));
      if (ctl.start) begin
        run_r <= 1'b1;
      end else if (cnt_r == pfx_pkg::CNT_W'(W - 1)) begin
        run_r <= 1'b0;
      end
    end
  end

  // Data path shift registers.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op_r    <= ctl.op;
      cnt_r   <= '0;
      acc_r   <= '0;
      rem_r   <= '0;
      neg_r   <= x[W-1] ^ y[W-1];
      dz_r    <= (y == '0);
      carry_r <= (ctl.op == pfx_pkg::OP_SUB);
      if (ctl.op == pfx_pkg::OP_DIV) begin
        a_r <= x[W-1] ? (W'(0) - x) : x;
        b_r <= y[W-1] ? (W'(0) - y) : y;
      end else if (ctl.op == pfx_pkg::OP_SUB) begin
        a_r <= x;
        b_r <= ~y;
      end else begin
        a_r <= x;
        b_r <= y;
      end
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      case (op_r)
        pfx_pkg::OP_ADD, pfx_pkg::OP_SUB: begin
          acc_r   <= {sum_bit, acc_r[W-1:1]};
          carry_r <= carry_nxt;
          a_r     <= a_r >> 1;
          b_r     <= b_r >> 1;
        end
        pfx_pkg::OP_MUL: begin
          acc_r <= acc_r + (b_r[0] ? a_r : W'(0));
          a_r   <= a_r << 1;
          b_r   <= b_r >> 1;
        end
        default: begin
          // Restoring division: the dividend shifts out, quotient bits shift in.
          if (!trial[W]) begin
            rem_r <= trial[W-1:0];
            a_r   <= {a_r[W-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[W-2:0], a_r[W-1]};
            a_r   <= {a_r[W-2:0], 1'b0};
          end
        end
      endcase
    end
  end

  // Result: the sign-corrected quotient, zero after division by zero, or the accumulator.
  always_ff @(posedge clk) begin
    if (fin_r) begin
      if (op_r == pfx_pkg::OP_DIV) begin
        if (dz_r) begin
          res_r <= '0;
        end else begin
          res_r <= neg_r ? (W'(0) - a_r) : a_r;
        end
      end else begin
        res_r <= acc_r;
      end
    end
  end

  assign result   = res_r;
  assign sts.done = done_r;
  assign sts.divz = dz_r && (op_r == pfx_pkg::OP_DIV);

endmodule

`default_nettype wire

>>> rtl/postfix_expression_evaluator_top.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_top: RPN evaluator on an operand stack
// Channel   Ports        Contents
// in        in_t*        tdata[7:0] symbol, tlast last_symbol
// out       out_t*       tdata[31:0] value, tdata[33:32] status
//
// A digit symbol is pushed as it is accepted. An operator is accepted with
// the pop of the right operand, then pops the left operand; the bit-serial
// arithmetic unit then loads, works through the bits and finishes, and the
// result is pushed. The final symbol adds a pop and the output register load.
// Reset empties the stack and clears the status; stack contents are left.
// A waiting result stalls the next expression only when it reaches the output.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_expression_evaluator_top #(
  parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] symbol
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // [31:0] value, [33:32] status, rest zero
);

  localparam int W    = pfx_pkg::DATA_W;
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDY  = 3'd1;
  localparam logic [2:0] S_RDX  = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [SP_W-1:0]  sp_r, sp_nxt;
  logic [1:0]       err_r, err_nxt;
  logic [1:0]       op_r, op_nxt;
  logic             last_r, last_nxt;
  logic             pend_r, pend_nxt;
  logic [W-1:0]     y_r, y_nxt;
  logic [1:0]       stat_r, stat_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [W-1:0]     out_value_r;
  logic [1:0]       out_status_r;
  logic             out_load;

  logic [W-1:0]     mem [STACK_DEPTH];
  logic [W-1:0]     mem_q_r;
  logic             rd_en, we;
  logic [AW-1:0]    rd_a, wr_a;
  logic [W-1:0]     wr_d;
  logic [SP_W-1:0]  sp_dec;

  logic             in_xfer, is_op;
  logic [1:0]       sym_op;
  logic [W-1:0]     popped;

  pfx_pkg::alu_ctl_t alu_ctl;
  pfx_pkg::alu_sts_t alu_sts;
  logic [W-1:0]      alu_res;

  pfx_serial_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (alu_ctl),
    .x      (popped),
    .y      (y_r),
    .sts    (alu_sts),
    .result (alu_res)
  );

  // Symbol decode.
  always_comb begin
    is_op  = 1'b1;
    sym_op = pfx_pkg::OP_ADD;
    case (in_tdata)
      pfx_pkg::SYM_ADD: sym_op = pfx_pkg::OP_ADD;
      pfx_pkg::SYM_SUB: sym_op = pfx_pkg::OP_SUB;
      pfx_pkg::SYM_MUL: sym_op = pfx_pkg::OP_MUL;
      pfx_pkg::SYM_DIV: sym_op = pfx_pkg::OP_DIV;
      default:          is_op  = 1'b0;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign sp_dec    = sp_r - 1'b1;
  assign popped    = pend_r ? mem_q_r : '1;
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  // Sequencer: pops, pushes, the arithmetic request, the final pop and the output load.
  always_comb begin
    state_nxt     = state_r;
    sp_nxt        = sp_r;
    err_nxt       = err_r;
    op_nxt        = op_r;
    last_nxt      = last_r;
    pend_nxt      = pend_r;
    y_nxt         = y_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    rd_en         = 1'b0;
    rd_a          = sp_dec[AW-1:0];
    we            = 1'b0;
    wr_a          = sp_r[AW-1:0];
    wr_d          = alu_res;
    alu_ctl.start = 1'b0;
    alu_ctl.op    = op_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          last_nxt = in_tlast;
          op_nxt   = sym_op;
          if (is_op) begin
            // Pop the right operand.
            pend_nxt  = (sp_r != '0);
            state_nxt = S_RDY;
            if (sp_r != '0) begin
              rd_en  = 1'b1;
              sp_nxt = sp_dec;
            end else begin
              err_nxt = pfx_pkg::merge_err(err_r, pfx_pkg::ST_UNDER);
            end
          end else begin
            // Push the character code less the digit offset.
            wr_d      = {{(W - pfx_pkg::SYM_W){1'b0}}, in_tdata} - W'(pfx_pkg::SYM_ZERO);
            state_nxt = in_tlast ? S_FIN : S_IDLE;
            if (sp_r < SP_W'(STACK_DEPTH)) begin
              we     = 1'b1;
              sp_nxt = sp_r + 1'b1;
            end else begin
              err_nxt = pfx_pkg::merge_err(err_r, pfx_pkg::ST_OVER);
            end
          end
        end
      end
      S_RDY: begin
        // Latch the right operand and pop the left one.
        y_nxt     = popped;
        pend_nxt  = (sp_r != '0);
        state_nxt = S_RDX;
        if (sp_r != '0) begin
          rd_en  = 1'b1;
          sp_nxt = sp_dec;
        end else begin
          err_nxt = pfx_pkg::merge_err(err_r, pfx_pkg::ST_UNDER);
        end
      end
      S_RDX: begin
        alu_ctl.start = 1'b1;
        state_nxt     = S_CALC;
      end
      S_CALC: begin
        // An operator has popped at least once or found the stack empty,
        // so its push always finds room.
        if (alu_sts.done) begin
          we     = 1'b1;
          sp_nxt = sp_r + 1'b1;
          if (alu_sts.divz) begin
            err_nxt = pfx_pkg::merge_err(err_r, pfx_pkg::ST_DIVZ);
          end
          state_nxt = last_r ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        // Final pop; the stack and the status start over.
        pend_nxt = (sp_r != '0);
        rd_en    = (sp_r != '0);
        stat_nxt = (sp_r != '0) ? err_r : pfx_pkg::merge_err(err_r, pfx_pkg::ST_UNDER);
        sp_nxt    = '0;
        err_nxt   = pfx_pkg::ST_OK;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      err_r       <= pfx_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    last_r <= last_nxt;
    pend_r <= pend_nxt;
    y_r    <= y_nxt;
    stat_r <= stat_nxt;
    if (out_load) begin
      out_value_r  <= popped;
      out_status_r <= stat_r;
    end
  end

  // Operand stack memory with registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_a] <= wr_d;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_a];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_status_r, out_value_r};

endmodule

`default_nettype wire

>>> sim/postfix_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// postfix_result_checker: scoreboard for the postfix expression evaluator
// Watches both stream channels. Every symbol transfer goes through a local
// copy of the operand stack. A symbol marked last queues the value and the
// status that the block should return. Every result transfer is compared
// field by field with the oldest queued expectation.
// ----------------------------------------------------------------------------
module postfix_result_checker #(
  parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,         // [7:0] symbol
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,        // [31:0] value, [33:32] status, rest zero
  output int          error_count,
  output int          pending_results
);

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } expr_result_t;

  // Local copy of the evaluator state.
  logic [31:0]  operand_stack [STACK_DEPTH];
  int           stack_depth;
  logic [1:0]   expr_status;
  expr_result_t expected_results [$];
  int           mismatches;

  initial begin
    stack_depth = 0;
    expr_status = pfx_pkg::ST_OK;
    mismatches  = 0;
  end

  // Only the first error of an expression is kept.
  task automatic note_error(input logic [1:0] code);
    if (expr_status == pfx_pkg::ST_OK) begin
      expr_status = code;
    end
  endtask

  // A push onto a full stack is dropped.
  task automatic push_operand(input logic [31:0] v);
    if (stack_depth >= STACK_DEPTH) begin
      note_error(pfx_pkg::ST_OVER);
    end else begin
      operand_stack[stack_depth] = v;
      stack_depth++;
    end
  endtask

  // A pop from an empty stack yields all ones.
  task automatic pop_operand(output logic [31:0] v);
    if (stack_depth == 0) begin
      note_error(pfx_pkg::ST_UNDER);
      v = 32'hFFFF_FFFF;
    end else begin
      stack_depth--;
      v = operand_stack[stack_depth];
    end
  endtask

  // Signed division on magnitudes, truncating toward zero. The most negative
  // value divided by minus one wraps back to itself.
  task automatic divide_toward_zero(input logic [31:0] x, input logic [31:0] y,
                                    output logic [31:0] q);
    logic [31:0] mag_x;
    logic [31:0] mag_y;
    mag_x = x[31] ? (32'd0 - x) : x;
    mag_y = y[31] ? (32'd0 - y) : y;
    if (mag_y == 32'd0) begin
      note_error(pfx_pkg::ST_DIVZ);
      q = 32'd0;
    end else begin
      q = mag_x / mag_y;
      if (x[31] != y[31]) begin
        q = 32'd0 - q;
      end
    end
  endtask

  // Run one accepted symbol through the stack and queue the result it ends.
  task automatic apply_symbol(input logic [7:0] sym, input logic last);
    logic [31:0]  lhs;
    logic [31:0]  rhs;
    logic [31:0]  res;
    expr_result_t done;
    if (sym == pfx_pkg::SYM_ADD || sym == pfx_pkg::SYM_SUB ||
        sym == pfx_pkg::SYM_MUL || sym == pfx_pkg::SYM_DIV) begin
      pop_operand(rhs);
      pop_operand(lhs);
      case (sym)
        pfx_pkg::SYM_ADD: res = lhs + rhs;
        pfx_pkg::SYM_SUB: res = lhs - rhs;
        pfx_pkg::SYM_MUL: res = lhs * rhs;
        default:          divide_toward_zero(lhs, rhs, res);
      endcase
      push_operand(res);
    end else begin
      push_operand({24'd0, sym} - {24'd0, pfx_pkg::SYM_ZERO});
    end
    if (last) begin
      pop_operand(done.value);
      done.status = expr_status;
      expected_results.push_back(done);
      stack_depth = 0;
      expr_status = pfx_pkg::ST_OK;
    end
  endtask

  // Compare one result transfer with the oldest expectation.
  task automatic check_result(input logic [39:0] beat);
    expr_result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result: value %0d, status %0d",
             $signed(beat[31:0]), beat[33:32]);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      if (beat[31:0] !== want.value) begin
        $error("value: expected %0d, got %0d", $signed(want.value), $signed(beat[31:0]));
        mismatches++;
      end
      if (beat[33:32] !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, beat[33:32]);
        mismatches++;
      end
      if (beat[39:34] !== 6'd0) begin
        $error("padding: expected %0d, got %0d", 6'd0, beat[39:34]);
        mismatches++;
      end
    end
  endtask

  // Results are checked before the symbol of the same edge is applied.
  always @(posedge clk) begin
    if (!rst_n) begin
      stack_depth = 0;
      expr_status = pfx_pkg::ST_OK;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        check_result(out_tdata);
      end
      if (in_tvalid && in_tready) begin
        apply_symbol(in_tdata, in_tlast);
      end
    end
    error_count     <= mismatches;
    pending_results <= expected_results.size();
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for postfix_expression_evaluator_top
// Sends a few directed expressions for the arithmetic corners, underflow and
// division by zero, then random expressions, mostly well formed, some deep
// enough to fill the stack and some plain noise. Both channels stall at
// random except in one steady window. The checker module does the scoring.
// ----------------------------------------------------------------------------
module testbench;

  localparam int STACK_DEPTH   = pfx_pkg::STACK_DEPTH_DEF;
  localparam int SYMBOL_TARGET = 600;
  localparam int IDLE_LIMIT    = 5000;
  localparam int DRAIN_CYCLES  = 40;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'd0;   // [7:0] symbol
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [39:0] out_tdata;            // [31:0] value, [33:32] status, rest zero
  logic        steady      = 1'b0;
  int          error_count;
  int          pending_results;
  int          symbols_sent = 0;
  int          quiet_cycles = 0;
  logic [7:0]  expr_buf [$];

  postfix_expression_evaluator_top #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  postfix_result_checker #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .error_count     (error_count),
    .pending_results (pending_results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: stalls about a third of the time outside the steady window.
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 32);
  end

  // Abort when neither channel has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic is_operator(input logic [7:0] sym);
    return sym == pfx_pkg::SYM_ADD || sym == pfx_pkg::SYM_SUB ||
           sym == pfx_pkg::SYM_MUL || sym == pfx_pkg::SYM_DIV;
  endfunction

  // Operands are mostly decimal digits, sometimes any other byte.
  task automatic add_operand();
    logic [7:0] sym;
    if ($urandom_range(0, 99) < 80) begin
      sym = pfx_pkg::SYM_ZERO + 8'($urandom_range(0, 9));
    end else begin
      sym = 8'($urandom_range(0, 255));
      while (is_operator(sym)) begin
        sym = 8'($urandom_range(0, 255));
      end
    end
    expr_buf.push_back(sym);
  endtask

  task automatic add_operator();
    case ($urandom_range(0, 3))
      0:       expr_buf.push_back(pfx_pkg::SYM_ADD);
      1:       expr_buf.push_back(pfx_pkg::SYM_SUB);
      2:       expr_buf.push_back(pfx_pkg::SYM_MUL);
      default: expr_buf.push_back(pfx_pkg::SYM_DIV);
    endcase
  endtask

  // Hold one symbol until it is taken; the sender sometimes pauses after it.
  task automatic send_symbol(input logic [7:0] sym, input logic last);
    in_tdata  <= sym;
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    symbols_sent++;
    if (!steady && $urandom_range(0, 99) < 32) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Send the buffered expression with its final symbol marked last.
  task automatic send_expression();
    for (int i = 0; i < expr_buf.size(); i++) begin
      send_symbol(expr_buf[i], i == expr_buf.size() - 1);
    end
    expr_buf.delete();
  endtask

  // One random expression: well formed, stack filling, or noise.
  task automatic build_random_expression();
    int pick;
    int operands;
    int depth;
    pick  = $urandom_range(0, 99);
    depth = 0;
    if (pick < 75) begin
      operands = $urandom_range(1, 8);
      while (operands > 0 || depth > 1) begin
        if (operands > 0 && (depth < 2 || $urandom_range(0, 1))) begin
          add_operand();
          operands--;
          depth++;
        end else begin
          add_operator();
          depth--;
        end
      end
    end else if (pick < 85) begin
      // Around the stack depth; deeper ones overflow and the collapse runs past the bottom.
      operands = $urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 4);
      repeat (operands) add_operand();
      repeat (operands - 1) add_operator();
    end else begin
      repeat ($urandom_range(1, 10)) begin
        if ($urandom_range(0, 99) < 40) begin
          add_operator();
        end else begin
          expr_buf.push_back(8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Build the most negative value (128^4 * 8) and divide it by minus one.
    expr_buf = '{8'd176, 8'd176, pfx_pkg::SYM_MUL, 8'd176, pfx_pkg::SYM_MUL,
                 8'd176, pfx_pkg::SYM_MUL, pfx_pkg::SYM_ZERO + 8'd8, pfx_pkg::SYM_MUL,
                 pfx_pkg::SYM_ZERO, pfx_pkg::SYM_ZERO + 8'd1, pfx_pkg::SYM_SUB,
                 pfx_pkg::SYM_DIV};
    send_expression();
    // Division by zero.
    expr_buf = '{pfx_pkg::SYM_ZERO + 8'd5, pfx_pkg::SYM_ZERO, pfx_pkg::SYM_DIV};
    send_expression();
    // A space pushes minus sixteen; the quotient truncates toward zero.
    expr_buf = '{8'd32, pfx_pkg::SYM_ZERO + 8'd3, pfx_pkg::SYM_DIV};
    send_expression();
    // Lowest and highest symbol bytes.
    expr_buf = '{8'd0, 8'd255, pfx_pkg::SYM_SUB};
    send_expression();
    // Underflow first, then division by zero: the first error is kept.
    expr_buf = '{pfx_pkg::SYM_ADD, pfx_pkg::SYM_ZERO, pfx_pkg::SYM_DIV};
    send_expression();

    while (symbols_sent < SYMBOL_TARGET) begin
      steady <= (symbols_sent >= 300 && symbols_sent < 420);
      build_random_expression();
      send_expression();
    end
    in_tvalid <= 1'b0;
    steady    <= 1'b0;

    // Wait for every expected result, then a little longer for strays.
    do @(posedge clk); while (pending_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/pfx_pkg.sv
rtl/pfx_serial_alu.sv
rtl/postfix_expression_evaluator_top.sv
sim/postfix_result_checker.sv
sim/testbench.sv
